>>> sv/grrp_pkg.sv
// grrp_pkg: shared types, constants and helpers for the glyph row raster packer
// no dependencies; imported by every module of the block

package grrp_pkg;

    localparam int RASTER_BITS_DEF    = 16;
    localparam int MAX_ROW_PIXELS_DEF = 255;

    localparam int SRC_W         = 8;
    localparam int START_W       = 4;
    localparam int ROW_PIX_W     = 8;
    localparam int RASTER_WORD_W = 16;
    localparam int WORD_INDEX_W  = 5;
    localparam int NPIX_W        = 4;   // pixels taken from one byte, 1..8
    localparam int QUEUE_DEPTH   = 2;

    typedef logic [SRC_W-1:0]        src_byte_t;
    typedef logic [START_W-1:0]      start_bit_t;
    typedef logic [WORD_INDEX_W-1:0] word_index_t;

    // one byte's worth of work for the back end
    typedef struct packed {
        src_byte_t           bits;      // leftmost pixel in bit 7, unused pixels zero
        logic [NPIX_W-1:0]   npix;
        logic                new_row;
        start_bit_t          start_bit;
        logic                last;
    } cmd_t;

    function automatic src_byte_t reverse_byte(input src_byte_t v);
        src_byte_t r;
        r = '0;
        for (int j = 0; j < SRC_W; j++)
        begin
            r[SRC_W-1-j] = v[j];
        end
        return r;
    endfunction

endpackage

>>> sv/grrp_front.sv
// grrp_front: accepts glyph bytes, tracks pixels left in the row, drops stray bytes
// depends on grrp_pkg; pushes cmd_t words into grrp_cmd_queue

module grrp_front
    import grrp_pkg::*;
#(
    parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SRC_W-1:0]     src_byte,
    input  logic                 row_start,
    input  logic [START_W-1:0]   start_bit,
    input  logic [ROW_PIX_W-1:0] row_pixels,
    input  logic                 q_ready,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    localparam int PL_W = $clog2(MAX_ROW_PIXELS + 1);

    logic            bit_order_msb_reg;
    logic [PL_W-1:0] pixels_left_reg;
    logic [PL_W-1:0] pixels_left_next;
    logic [PL_W-1:0] left_eff;
    logic [NPIX_W-1:0] npix;
    src_byte_t       bits;
    src_byte_t       pix_mask;
    logic            accept;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (row_start)
        begin
            if (32'(row_pixels) > 32'(MAX_ROW_PIXELS))
                left_eff = PL_W'(MAX_ROW_PIXELS);
            else
                left_eff = PL_W'(row_pixels);
        end
        else
        begin
            left_eff = pixels_left_reg;
        end

        if (32'(left_eff) < 32'd8)
            npix = left_eff[NPIX_W-1:0];
        else
            npix = NPIX_W'(8);

        bits     = bit_order_msb_reg ? src_byte : reverse_byte(src_byte);
        // keep only the pixels that belong to the row
        pix_mask = ~(8'hFF >> npix);

        q_cmd.bits      = bits & pix_mask;
        q_cmd.npix      = npix;
        q_cmd.new_row   = row_start;
        q_cmd.start_bit = start_bit;

        pixels_left_next = left_eff - PL_W'(npix);
        q_cmd.last       = (pixels_left_next == '0);
    end

    assign q_push = accept && (left_eff != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_order_msb_reg <= 1'b1;
            pixels_left_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                bit_order_msb_reg <= cfg_wr_data;
            if (accept)
            begin
                if (left_eff == '0)
                    pixels_left_reg <= '0;
                else
                    pixels_left_reg <= pixels_left_next;
            end
        end
    end

endmodule

>>> sv/grrp_cmd_queue.sv
// grrp_cmd_queue: short register queue of cmd_t between front and back
// depends on grrp_pkg

module grrp_cmd_queue
    import grrp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic pop_valid
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> sv/grrp_back.sv
// grrp_back: merges each byte's pixels into the raster accumulator and emits words
// depends on grrp_pkg; pops cmd_t words from grrp_cmd_queue

module grrp_back
    import grrp_pkg::*;
#(
    parameter int RASTER_BITS = RASTER_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  cmd_t                     q_cmd,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [RASTER_WORD_W-1:0] raster_word,
    output logic [WORD_INDEX_W-1:0]  word_index,
    output logic                     row_last
);

    localparam int BF_W = $clog2(RASTER_BITS + 1);
    localparam int WIN_W = 2 * RASTER_BITS;
    localparam int SH_W = $clog2(WIN_W);

    logic [RASTER_BITS-1:0]   acc_reg;
    logic [BF_W-1:0]          bits_free_reg;
    word_index_t              word_cnt_reg;

    logic                     out_valid_reg;
    logic [RASTER_WORD_W-1:0] out_word_reg;
    word_index_t              out_index_reg;
    logic                     out_last_reg;
    logic                     pend_valid_reg;
    logic [RASTER_WORD_W-1:0] pend_word_reg;
    word_index_t              pend_index_reg;

    logic [RASTER_BITS-1:0]   acc0;
    logic [BF_W-1:0]          bf0;
    word_index_t              wc0;
    logic [SH_W-1:0]          shamt;
    logic [WIN_W-1:0]         win;
    logic                     fill;
    logic [RASTER_BITS-1:0]   acc_next;
    logic [BF_W-1:0]          bits_free_next;
    word_index_t              word_cnt_next;
    logic                     out_free;
    logic                     take;

    assign out_free = !out_valid_reg || out_ready;
    assign take     = q_valid && !pend_valid_reg && out_free;
    assign q_pop    = take;

    always_comb
    begin
        if (q_cmd.new_row)
        begin
            acc0 = '0;
            bf0  = BF_W'(RASTER_BITS - 32'(q_cmd.start_bit));
            wc0  = '0;
        end
        else
        begin
            acc0 = acc_reg;
            bf0  = bits_free_reg;
            wc0  = word_cnt_reg;
        end

        // the byte's bit 7 lands on position bf0-1 of the upper half
        shamt = SH_W'(RASTER_BITS + 32'(bf0) - 8);
        win   = {acc0, {RASTER_BITS{1'b0}}} | (WIN_W'(q_cmd.bits) << shamt);
        fill  = (32'(q_cmd.npix) >= 32'(bf0));

        if (fill)
        begin
            acc_next       = win[RASTER_BITS-1:0];
            bits_free_next = BF_W'(32'(bf0) + RASTER_BITS - 32'(q_cmd.npix));
            word_cnt_next  = wc0 + 1'b1;
        end
        else
        begin
            acc_next       = win[WIN_W-1:RASTER_BITS];
            bits_free_next = bf0 - BF_W'(q_cmd.npix);
            word_cnt_next  = wc0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_word_reg  <= pend_word_reg;
                out_index_reg <= pend_index_reg;
                out_last_reg  <= 1'b1;
            end
            else if (take)
            begin
                if (fill)
                begin
                    out_word_reg  <= RASTER_WORD_W'(win[WIN_W-1:RASTER_BITS]);
                    out_index_reg <= wc0;
                    out_last_reg  <= 1'b0;
                end
                else
                begin
                    out_word_reg  <= acc_next[RASTER_WORD_W-1:0];
                    out_index_reg <= word_cnt_next;
                    out_last_reg  <= 1'b1;
                end
                pend_word_reg  <= acc_next[RASTER_WORD_W-1:0];
                pend_index_reg <= word_cnt_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            bits_free_reg  <= BF_W'(RASTER_BITS);
            word_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (q_cmd.last)
                begin
                    acc_reg       <= '0;
                    bits_free_reg <= BF_W'(RASTER_BITS);
                    word_cnt_reg  <= '0;
                end
                else
                begin
                    acc_reg       <= acc_next;
                    bits_free_reg <= bits_free_next;
                    word_cnt_reg  <= word_cnt_next;
                end
            end

            if (out_free)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    pend_valid_reg <= 1'b0;
                end
                else if (take)
                begin
                    out_valid_reg  <= fill || q_cmd.last;
                    pend_valid_reg <= fill && q_cmd.last;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign raster_word = out_word_reg;
    assign word_index  = out_index_reg;
    assign row_last    = out_last_reg;

endmodule

>>> sv/glyph_row_raster_packer.sv
// Glyph row raster packer. Takes one glyph row byte per cycle while the command queue has
// room and packs its pixels, from the left, into 16-bit raster words starting start_bit
// positions into the row's first word; every filled word comes out with its index and the
// row's final partial word with row_last. Sustained rate is one byte per clock while the
// output is ready and no second word is pending. A byte that both fills a word and ends its
// row gives two words and holds the merge stage while the second word is sent. The byte is
// written into the command queue when accepted and the merge stage registers its first word
// when it takes the byte. bit_order_msb is written through cfg_wr_en and cfg_wr_data; the
// user must write it only while the block is idle, which the block itself does not enforce.
// depends on grrp_pkg, grrp_front, grrp_cmd_queue, grrp_back

module glyph_row_raster_packer
    import grrp_pkg::*;
#(
    parameter int RASTER_BITS    = RASTER_BITS_DEF,
    parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SRC_W-1:0]         src_byte,
    input  logic                     row_start,
    input  logic [START_W-1:0]       start_bit,
    input  logic [ROW_PIX_W-1:0]     row_pixels,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [RASTER_WORD_W-1:0] raster_word,
    output logic [WORD_INDEX_W-1:0]  word_index,
    output logic                     row_last
);

    logic q_ready;
    logic q_push;
    cmd_t push_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t pop_cmd;

    grrp_front #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .src_byte    (src_byte),
        .row_start   (row_start),
        .start_bit   (start_bit),
        .row_pixels  (row_pixels),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    grrp_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_cmd    (pop_cmd),
        .pop_valid  (q_valid)
    );

    grrp_back #(
        .RASTER_BITS (RASTER_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (pop_cmd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .raster_word (raster_word),
        .word_index  (word_index),
        .row_last    (row_last)
    );

endmodule

>>> sv/grrp_checker.sv
// grrp_checker: port-level checks for glyph_row_raster_packer, bound to the top level
// depends on grrp_pkg

module grrp_checker
    import grrp_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [RASTER_WORD_W-1:0] raster_word,
    input logic [WORD_INDEX_W-1:0]  word_index,
    input logic                     row_last
);

    logic        prev_open_reg;   // last word sent was not a row end
    word_index_t prev_index_reg;
    logic [3:0]  quiet_reg;       // cycles with no input and output always ready

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_open_reg  <= 1'b0;
            prev_index_reg <= '0;
            quiet_reg      <= '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                prev_open_reg  <= !row_last;
                prev_index_reg <= word_index;
            end
            if ((in_valid && in_ready) || !out_ready)
                quiet_reg <= '0;
            else if (quiet_reg != 4'hF)
                quiet_reg <= quiet_reg + 1'b1;
        end
    end

    // stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(raster_word)
            && $stable(word_index) && $stable(row_last))
        else $error("stalled output word changed");

    // inside a row the index steps by one, or a new row restarts at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && prev_open_reg |->
            (word_index == prev_index_reg + 1'b1) || (word_index == '0))
        else $error("word index skipped within a row");

    // with no new bytes and a ready sink everything drains
    assert property (@(posedge clk) disable iff (!rst_n)
        quiet_reg >= 4'd8 |-> !out_valid)
        else $error("output still valid after drain time");

endmodule

bind glyph_row_raster_packer grrp_checker u_grrp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .raster_word (raster_word),
    .word_index  (word_index),
    .row_last    (row_last)
);
